// ===== sv/ptdq_pkg.sv =====
// Package: shared constants and codes for the periodic timer deadline queue.
package ptdq_pkg;
  localparam int unsigned TimerSlots = 16;
  localparam int unsigned FireLimit  = 32;
  localparam int unsigned TimeW      = 48;
  localparam int unsigned IdW        = 32;
  localparam int unsigned PeriodW    = 32;

  localparam logic [1:0] FuncAdd    = 2'd0;
  localparam logic [1:0] FuncRemove = 2'd1;
  localparam logic [1:0] FuncTick   = 2'd2;

  localparam logic [2:0] KindAdded    = 3'd0;
  localparam logic [2:0] KindRemoved  = 3'd1;
  localparam logic [2:0] KindFired    = 3'd2;
  localparam logic [2:0] KindTickDone = 3'd3;
  localparam logic [2:0] KindFull     = 3'd4;
endpackage

// ===== sv/periodic_timer_deadline_queue_top.sv =====
// Top level: timer table in a slot memory, scanned one slot per cycle.
//
//  channel | valid   | stall   | payload
//  in      | valid_i | stall_o | func_i deadline_i period_i target_id_i now_i
//  out     | valid_o | stall_i | kind_o timer_id_o found_o next_valid_o
//          |         |         | next_deadline_o last_o
//
// One scan pass reads every slot once, one read per cycle through the registered
// memory read, and closes once the last read is taken. Add, remove and the spare
// code take the accept step, one scan pass and the result. Each fired timer adds
// an update step, a pass for its result, its result and a pass to pick the next
// firing. Valid bits live in flip-flops that reset clears; the slot memory needs no
// clearing. A stalled result holds the block; input is taken only when idle.
module periodic_timer_deadline_queue_top #(
  parameter int unsigned TIMER_SLOTS = ptdq_pkg::TimerSlots,
  parameter int unsigned FIRE_LIMIT  = ptdq_pkg::FireLimit
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  func_i,
  input  logic [47:0] deadline_i,
  input  logic [31:0] period_i,
  input  logic [31:0] target_id_i,
  input  logic [47:0] now_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] timer_id_o,
  output logic        found_o,
  output logic        next_valid_o,
  output logic [47:0] next_deadline_o,
  output logic        last_o
);
  localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned FW = $clog2(FIRE_LIMIT + 1);
  localparam logic [47:0] TimeMax = '1;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StFire = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  // one memory entry: id, deadline, period
  typedef struct packed {
    logic [31:0] id;
    logic [47:0] dl;
    logic [31:0] per;
  } slot_t;

  slot_t mem_q [TIMER_SLOTS];
  slot_t rd_q;
  logic  we;
  logic [SW-1:0] wa;
  slot_t wd;
  logic [SW-1:0] ra;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  state_e state_q, state_d;
  logic [TIMER_SLOTS-1:0] vld_q, vld_d;
  logic [31:0] last_id_q, last_id_d;
  logic [1:0]  func_q, func_d;
  logic [47:0] now_q, now_d;
  logic [31:0] tid_q, tid_d;
  logic [CW-1:0] cnt_q, cnt_d;      // read address counter
  logic        rv_q, rv_d;          // rd_q holds slot rslot_q
  logic [SW-1:0] rslot_q, rslot_d;
  logic        bv_q, bv_d;          // best found
  logic [SW-1:0] bslot_q, bslot_d;
  slot_t       best_q, best_d;
  logic [FW-1:0] nfire_q, nfire_d;
  logic        hit_q, hit_d;
  logic        fire_pend_q, fire_pend_d;
  logic [2:0]  kind_q, kind_d;
  logic [31:0] oid_q, oid_d;
  logic        ofound_q, ofound_d, olast_q, olast_d;
  logic        onv_q, onv_d;
  logic [47:0] ond_q, ond_d;

  logic [48:0] sum;
  logic        better;
  logic        free_any;
  logic [SW-1:0] free_idx;

  function automatic logic [2:0] KindOf(input logic [1:0] f);
    case (f)
      ptdq_pkg::FuncAdd:    KindOf = ptdq_pkg::KindAdded;
      ptdq_pkg::FuncRemove: KindOf = ptdq_pkg::KindRemoved;
      default:              KindOf = ptdq_pkg::KindTickDone;
    endcase
  endfunction

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!vld_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign sum = {1'b0, best_q.dl} + {17'd0, best_q.per};
  assign better = !bv_q || (rd_q.dl < best_q.dl) ||
                  ((rd_q.dl == best_q.dl) && (rd_q.id < best_q.id));

  always_comb begin
    state_d = state_q; vld_d = vld_q; last_id_d = last_id_q;
    func_d = func_q; now_d = now_q; tid_d = tid_q;
    cnt_d = cnt_q; rv_d = 1'b0; rslot_d = cnt_q[SW-1:0];
    bv_d = bv_q; bslot_d = bslot_q; best_d = best_q;
    nfire_d = nfire_q; hit_d = hit_q; fire_pend_d = fire_pend_q;
    kind_d = kind_q; oid_d = oid_q; ofound_d = ofound_q; olast_d = olast_q;
    onv_d = onv_q; ond_d = ond_q;
    we = 1'b0; wa = free_idx; wd = '{id: last_id_q + 32'd1, dl: deadline_i, per: period_i};
    ra = cnt_q[SW-1:0];
    case (state_q)
      StIdle: begin
        if (valid_i) begin
          func_d = func_i; now_d = now_i;
          tid_d = target_id_i;
          hit_d = 1'b0; nfire_d = '0; oid_d = '0; ofound_d = 1'b0;
          kind_d = KindOf(func_i);
          if (func_i == ptdq_pkg::FuncAdd) begin
            if (free_any) begin
              we = 1'b1;
              vld_d[free_idx] = 1'b1;
              last_id_d = last_id_q + 32'd1;
              oid_d = last_id_q + 32'd1;
            end else begin
              kind_d = ptdq_pkg::KindFull;
            end
          end else if (func_i == ptdq_pkg::FuncRemove) begin
            oid_d = target_id_i;
          end
          cnt_d = '0; bv_d = 1'b0; state_d = StScan;
        end
      end
      StScan: begin
        if (cnt_q < CW'(TIMER_SLOTS)) begin
          rv_d = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
        if (rv_q && vld_q[rslot_q]) begin
          if (func_q == ptdq_pkg::FuncRemove && rd_q.id == tid_q) begin
            vld_d[rslot_q] = 1'b0;
            hit_d = 1'b1;
          end else if (better) begin
            bv_d = 1'b1; bslot_d = rslot_q; best_d = rd_q;
          end
        end
        if (!rv_q && cnt_q == CW'(TIMER_SLOTS)) begin
          onv_d = bv_q; ond_d = bv_q ? best_q.dl : '0;
          ofound_d = (func_q == ptdq_pkg::FuncRemove) && hit_q;
          if (func_q == ptdq_pkg::FuncTick) begin
            if (fire_pend_q) begin
              // result for the previous firing, table already updated
              kind_d = ptdq_pkg::KindFired; olast_d = 1'b0;
              state_d = StOut;
            end else if (bv_q && best_q.dl <= now_q && nfire_q < FW'(FIRE_LIMIT)) begin
              state_d = StFire;
            end else begin
              kind_d = ptdq_pkg::KindTickDone; oid_d = '0; olast_d = 1'b1;
              state_d = StOut;
            end
          end else begin
            olast_d = 1'b1; state_d = StOut;
          end
        end
      end
      StFire: begin
        oid_d = best_q.id;
        nfire_d = nfire_q + FW'(1);
        if (best_q.per != '0) begin
          we = 1'b1; wa = bslot_q;
          wd = '{id: best_q.id, dl: sum[48] ? TimeMax : sum[47:0], per: best_q.per};
        end else begin
          vld_d[bslot_q] = 1'b0;
        end
        fire_pend_d = 1'b1;
        cnt_d = '0; bv_d = 1'b0; state_d = StScan;
      end
      StOut: begin
        if (!stall_i) begin
          if (olast_q) begin
            state_d = StIdle;
          end else begin
            fire_pend_d = 1'b0;
            cnt_d = '0; bv_d = 1'b0; state_d = StScan;
            // rescan: decide next firing from the current table
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; vld_q <= '0; last_id_q <= '0;
      cnt_q <= '0; rv_q <= 1'b0; bv_q <= 1'b0; nfire_q <= '0;
      hit_q <= 1'b0; fire_pend_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      state_q <= state_d; vld_q <= vld_d; last_id_q <= last_id_d;
      cnt_q <= cnt_d; rv_q <= rv_d; bv_q <= bv_d; nfire_q <= nfire_d;
      hit_q <= hit_d; fire_pend_q <= fire_pend_d; olast_q <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; now_q <= now_d; tid_q <= tid_d;
    rslot_q <= rslot_d; bslot_q <= bslot_d; best_q <= best_d;
    kind_q <= kind_d; oid_q <= oid_d; ofound_q <= ofound_d;
    onv_q <= onv_d; ond_q <= ond_d;
  end

  assign stall_o         = (state_q != StIdle);
  assign valid_o         = (state_q == StOut);
  assign kind_o          = kind_q;
  assign timer_id_o      = oid_q;
  assign found_o         = ofound_q;
  assign next_valid_o    = onv_q;
  assign next_deadline_o = ond_q;
  assign last_o          = olast_q;
endmodule

// ===== sv/ptdq_checker.sv =====
// Checker: port-level properties of the timer queue, bound to the top level.
module ptdq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [2:0]  kind_o,
  input logic [31:0] timer_id_o,
  input logic        found_o,
  input logic        next_valid_o,
  input logic [47:0] next_deadline_o,
  input logic        last_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(kind_o) && $stable(timer_id_o))
    else $error("stalled result changed");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("input open while result pending");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !next_valid_o |-> next_deadline_o == 48'd0)
    else $error("deadline without pending timer");
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_o != (kind_o == ptdq_pkg::KindFired)))
    else $error("last flag and kind disagree");
  a_found_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && found_o |-> kind_o == ptdq_pkg::KindRemoved)
    else $error("found outside remove");
endmodule

bind periodic_timer_deadline_queue_top ptdq_checker u_ptdq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .kind_o(kind_o), .timer_id_o(timer_id_o),
  .found_o(found_o), .next_valid_o(next_valid_o), .next_deadline_o(next_deadline_o),
  .last_o(last_o)
);
